### hdl/ram_disk_port_controller_macros.svh
// Assertion macros shared by the RAM disk port controller modules.
`ifndef RAM_DISK_PORT_CONTROLLER_MACROS_SVH
`define RAM_DISK_PORT_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define RDPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define RDPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rdpc_pkg.sv
// Types and constants shared by the RAM disk port controller modules.
`default_nettype none

package rdpc_pkg;

	localparam int unsigned STORE_AW   = 23;
	localparam int unsigned STORE_BYTES = 8388608;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned HIGH_USED_W = 5;

	localparam logic [1:0] PORT_DATA   = 2'd0;
	localparam logic [1:0] PORT_LOW    = 2'd1;
	localparam logic [1:0] PORT_HIGH   = 2'd2;
	localparam logic [1:0] PORT_STATUS = 2'd3;

	// One accepted bus access as it travels down the pipeline.
	typedef struct packed {
		logic       op;
		logic       half;
		logic [1:0] port;
		logic [7:0] wdata;
	} req_t;

	// Access issued to the disk store.
	typedef struct packed {
		logic                en;
		logic                we;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          wdata;
	} mem_cmd_t;

endpackage

`default_nettype wire

### hdl/rdpc_regs.sv
// Sector registers, byte counters and store address generation for both halves.
`default_nettype none
`include "ram_disk_port_controller_macros.svh"

module rdpc_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire rdpc_pkg::req_t    req,
	output rdpc_pkg::mem_cmd_t     mem_cmd,
	output logic [7:0]             reg_rdata
);

	logic [7:0]                   sector_q [4];
	logic [rdpc_pkg::CNT_W-1:0]   cnt_q [2];
	logic [1:0]                   slot;
	logic                         is_sector;
	logic [rdpc_pkg::STORE_AW-1:0] base_term;
	logic [rdpc_pkg::STORE_AW-1:0] high_term;
	logic [rdpc_pkg::STORE_AW-1:0] low_term;
	logic [rdpc_pkg::STORE_AW-1:0] cnt_term;

	// Entry half*2 holds the high sector register, half*2+1 the low one.
	assign slot      = {req.half, req.port == rdpc_pkg::PORT_LOW};
	assign is_sector = (req.port == rdpc_pkg::PORT_LOW) || (req.port == rdpc_pkg::PORT_HIGH);
	assign reg_rdata = sector_q[slot];

	// The sum is kept at store width so that it wraps round the end of the disk.
	assign base_term = {req.half, 22'd0};
	assign high_term = {1'b0, sector_q[{req.half, 1'b0}][rdpc_pkg::HIGH_USED_W-1:0], 17'd0};
	assign low_term  = {6'd0, sector_q[{req.half, 1'b1}], 9'd0};
	assign cnt_term  = {7'd0, cnt_q[req.half]};

	always_comb begin
		mem_cmd.en    = valid_s1 && (req.port == rdpc_pkg::PORT_DATA);
		mem_cmd.we    = req.op;
		mem_cmd.addr  = base_term + high_term + low_term + cnt_term;
		mem_cmd.wdata = req.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) sector_q[i] <= 8'd0;
			for (int i = 0; i < 2; i++) cnt_q[i] <= '0;
		end else if (valid_s1) begin
			if (req.port == rdpc_pkg::PORT_DATA) begin
				cnt_q[req.half] <= cnt_q[req.half] + 16'd1;
			end else if (is_sector && req.op) begin
				sector_q[slot]  <= req.wdata;
				cnt_q[req.half] <= '0;
			end
		end
	end

	`RDPC_ASSERT_NEXT(a_sector_write_clears_cnt, valid_s1 && req.op && is_sector, cnt_q[$past(req.half)] == 16'd0, "sector write did not clear the byte counter")
	`RDPC_ASSERT_NEXT(a_data_beat_bumps_cnt, valid_s1 && (req.port == rdpc_pkg::PORT_DATA), cnt_q[$past(req.half)] == $past(cnt_q[req.half]) + 16'd1, "data beat did not advance the byte counter")

endmodule

`default_nettype wire

### hdl/rdpc_store.sv
// 8 MiB byte store with one synchronous read/write port.
`default_nettype none

module rdpc_store (
	input  wire logic               clk,
	input  wire rdpc_pkg::mem_cmd_t cmd,
	output logic [7:0]              rdata
);

	logic [7:0] mem [rdpc_pkg::STORE_BYTES];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.we) begin
				mem[cmd.addr] <= cmd.wdata;
			end else begin
				rd_q <= mem[cmd.addr];
			end
		end
	end

	assign rdata = rd_q;

endmodule

`default_nettype wire

### hdl/ram_disk_port_controller.sv
// Top level of the two-half RAM disk port controller.
//
// The block takes one bus access per clock cycle and never raises busy. Each
// access produces exactly one result: done is high for one cycle once the
// access has passed the valid_s1 and done_s2 registers, with rdata valid in
// that cycle; the receiver cannot stall it. The result path runs through one
// register stage for the request and the synchronous read of the disk store.
// Sector register and counter updates land at the edge where the store is
// accessed, so a following access always sees them.
`default_nettype none
`include "ram_disk_port_controller_macros.svh"

module ram_disk_port_controller (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       op,
	input  wire logic [2:0] port_addr,
	input  wire logic [7:0] wdata,
	output logic            done,
	output logic [7:0]      rdata
);

	logic               accept;
	logic               valid_s1;
	rdpc_pkg::req_t     req_s1;
	rdpc_pkg::mem_cmd_t mem_cmd;
	logic [7:0]         reg_rdata;
	logic [7:0]         store_rdata;
	logic               done_s2;
	logic               mem_sel_s2;
	logic [7:0]         regv_s2;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.op    <= op;
			req_s1.half  <= port_addr[2];
			req_s1.port  <= port_addr[1:0];
			req_s1.wdata <= wdata;
		end
		mem_sel_s2 <= !req_s1.op && (req_s1.port == rdpc_pkg::PORT_DATA);
		// Writes and the status port read back as zero.
		if (!req_s1.op && ((req_s1.port == rdpc_pkg::PORT_LOW) ||
			(req_s1.port == rdpc_pkg::PORT_HIGH))) begin
			regv_s2 <= reg_rdata;
		end else begin
			regv_s2 <= 8'd0;
		end
	end

	rdpc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.req       (req_s1),
		.mem_cmd   (mem_cmd),
		.reg_rdata (reg_rdata)
	);

	rdpc_store u_store (
		.clk   (clk),
		.cmd   (mem_cmd),
		.rdata (store_rdata)
	);

	assign done  = done_s2;
	assign rdata = mem_sel_s2 ? store_rdata : regv_s2;

	`RDPC_ASSERT_NEXT(a_beat_gives_result, valid_s1, done, "accepted beat produced no result")
	`RDPC_ASSERT_NOW(a_result_has_beat, done, $past(valid_s1), "result without an accepted beat")
	`RDPC_ASSERT_NEXT(a_write_reads_zero, valid_s1 && req_s1.op, rdata == 8'd0, "write beat returned nonzero data")

endmodule

`default_nettype wire

### dv/tb_ram_disk_port_controller.sv
// Self-checking testbench for the two-half RAM disk port controller.
module tb_ram_disk_port_controller;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;
	localparam logic HALF_LO  = 1'b0;
	localparam logic HALF_HI  = 1'b1;
	localparam int unsigned HALF_BASE  = 4096 * 1024;
	localparam int unsigned HIGH_SHIFT = 17;
	localparam int unsigned LOW_SHIFT  = 9;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned ITEMS_PER_PHASE = 100;

	typedef struct packed {
		logic       wr;
		logic [2:0] pa;
		logic [7:0] wd;
		logic       typed;
		logic [7:0] rd;
	} access_row_t;

	// Expected bytes are typed in for reset values, sector readback and the
	// bytes written at the top of the lower half and the bottom of the upper.
	localparam access_row_t DIRECTED_ROWS [0:23] = '{
		'{OP_READ,  {HALF_LO, rdpc_pkg::PORT_LOW},    8'hFF, 1'b1, 8'h00},
		'{OP_READ,  {HALF_LO, rdpc_pkg::PORT_HIGH},   8'h00, 1'b1, 8'h00},
		'{OP_READ,  {HALF_HI, rdpc_pkg::PORT_LOW},    8'hFF, 1'b1, 8'h00},
		'{OP_READ,  {HALF_HI, rdpc_pkg::PORT_HIGH},   8'h00, 1'b1, 8'h00},
		'{OP_READ,  {HALF_LO, rdpc_pkg::PORT_STATUS}, 8'h00, 1'b1, 8'h00},
		'{OP_WRITE, {HALF_HI, rdpc_pkg::PORT_STATUS}, 8'hFF, 1'b1, 8'h00},
		'{OP_WRITE, {HALF_LO, rdpc_pkg::PORT_STATUS}, 8'h00, 1'b1, 8'h00},
		'{OP_READ,  {HALF_HI, rdpc_pkg::PORT_STATUS}, 8'hFF, 1'b1, 8'h00},
		'{OP_WRITE, {HALF_LO, rdpc_pkg::PORT_HIGH},   8'hFF, 1'b1, 8'h00},
		'{OP_READ,  {HALF_LO, rdpc_pkg::PORT_HIGH},   8'h00, 1'b1, 8'hFF},
		'{OP_WRITE, {HALF_LO, rdpc_pkg::PORT_LOW},    8'hFF, 1'b1, 8'h00},
		'{OP_READ,  {HALF_LO, rdpc_pkg::PORT_LOW},    8'h00, 1'b1, 8'hFF},
		'{OP_WRITE, {HALF_LO, rdpc_pkg::PORT_DATA},   8'hA5, 1'b1, 8'h00},
		'{OP_WRITE, {HALF_LO, rdpc_pkg::PORT_DATA},   8'h5A, 1'b1, 8'h00},
		'{OP_WRITE, {HALF_HI, rdpc_pkg::PORT_LOW},    8'h00, 1'b1, 8'h00},
		'{OP_WRITE, {HALF_HI, rdpc_pkg::PORT_DATA},   8'hFF, 1'b1, 8'h00},
		'{OP_WRITE, {HALF_HI, rdpc_pkg::PORT_DATA},   8'h00, 1'b1, 8'h00},
		'{OP_WRITE, {HALF_LO, rdpc_pkg::PORT_HIGH},   8'hFF, 1'b1, 8'h00},
		'{OP_READ,  {HALF_LO, rdpc_pkg::PORT_DATA},   8'h00, 1'b1, 8'hA5},
		'{OP_READ,  {HALF_LO, rdpc_pkg::PORT_DATA},   8'hFF, 1'b1, 8'h5A},
		'{OP_WRITE, {HALF_HI, rdpc_pkg::PORT_HIGH},   8'h00, 1'b1, 8'h00},
		'{OP_READ,  {HALF_HI, rdpc_pkg::PORT_DATA},   8'h00, 1'b1, 8'hFF},
		'{OP_READ,  {HALF_HI, rdpc_pkg::PORT_DATA},   8'h00, 1'b1, 8'h00},
		'{OP_READ,  {HALF_HI, rdpc_pkg::PORT_HIGH},   8'h55, 1'b0, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       op = 1'b0;
	logic [2:0] port_addr = 3'd0;
	logic [7:0] wdata = 8'h00;
	logic       busy;
	logic       done;
	logic [7:0] rdata;

	// Mirror of the block's registers and of every store byte written so far.
	logic [7:0]                 sector_mirror [4];
	logic [rdpc_pkg::CNT_W-1:0] cnt_mirror [2];
	logic [7:0]                 disk_mirror [int unsigned];

	logic [7:0]  rdata_expected [$];
	logic [7:0]  rdata_want;
	int unsigned idle_pct = 0;
	int unsigned fail_count = 0;
	int unsigned beats_sent = 0;
	int unsigned results_checked = 0;
	int unsigned store_reads = 0;
	int unsigned cycle_count = 0;

	ram_disk_port_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.port_addr(port_addr),
		.wdata(wdata),
		.done(done),
		.rdata(rdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Store address that the next data access of a half will touch.
	function automatic logic [rdpc_pkg::STORE_AW-1:0] data_addr(input logic half);
		int unsigned sum;
		sum = (half ? HALF_BASE : 0)
			+ (int'(sector_mirror[{half, 1'b0}][rdpc_pkg::HIGH_USED_W-1:0]) << HIGH_SHIFT)
			+ (int'(sector_mirror[{half, 1'b1}]) << LOW_SHIFT)
			+ int'(cnt_mirror[half]);
		return sum[rdpc_pkg::STORE_AW-1:0];
	endfunction

	// Applies one access to the mirror and returns the byte the block must read.
	function automatic logic [7:0] predict_access(input logic wr, input logic [2:0] pa,
			input logic [7:0] wd);
		logic                          half;
		logic [1:0]                    port;
		logic [rdpc_pkg::STORE_AW-1:0] a;
		logic [7:0]                    rd;
		half = pa[2];
		port = pa[1:0];
		rd = 8'h00;
		case (port)
		rdpc_pkg::PORT_DATA: begin
			a = data_addr(half);
			cnt_mirror[half] = cnt_mirror[half] + 16'd1;
			if (wr)
				disk_mirror[a] = wd;
			else if (disk_mirror.exists(a))
				rd = disk_mirror[a];
		end
		rdpc_pkg::PORT_STATUS: rd = 8'h00;
		default: begin
			if (wr) begin
				sector_mirror[{half, port == rdpc_pkg::PORT_LOW}] = wd;
				cnt_mirror[half] = '0;
			end else begin
				rd = sector_mirror[{half, port == rdpc_pkg::PORT_LOW}];
			end
		end
		endcase
		return rd;
	endfunction

	task automatic issue_access(input logic wr, input logic [2:0] pa, input logic [7:0] wd,
			input logic typed, input logic [7:0] typed_rd);
		logic [7:0] rd;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= wr;
		port_addr <= pa;
		wdata <= wd;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		rd = predict_access(wr, pa, wd);
		rdata_expected.push_back(typed ? typed_rd : rd);
		beats_sent++;
		if (pa[1:0] == rdpc_pkg::PORT_DATA && wr == OP_READ)
			store_reads++;
	endtask

	// Fills a run of bytes from one sector origin across a boundary, then reads
	// the bytes beyond it back through the other half set to sector zero.
	task automatic sweep_half(input logic half, input logic [7:0] high_val,
			input logic [7:0] low_val, input int unsigned span, input int unsigned tail);
		issue_access(OP_WRITE, {half, rdpc_pkg::PORT_HIGH}, high_val, 1'b0, 8'h00);
		issue_access(OP_WRITE, {half, rdpc_pkg::PORT_LOW}, low_val, 1'b0, 8'h00);
		for (int unsigned k = 0; k < span; k++)
			issue_access(OP_WRITE, {half, rdpc_pkg::PORT_DATA}, 8'($urandom_range(255)),
				1'b0, 8'h00);
		issue_access(OP_WRITE, {~half, rdpc_pkg::PORT_HIGH}, 8'h00, 1'b0, 8'h00);
		issue_access(OP_WRITE, {~half, rdpc_pkg::PORT_LOW}, 8'h00, 1'b0, 8'h00);
		for (int unsigned k = 0; k < tail; k++)
			issue_access(OP_READ, {~half, rdpc_pkg::PORT_DATA}, 8'($urandom_range(255)),
				1'b0, 8'h00);
	endtask

	task automatic random_access();
		logic        wr;
		logic        half;
		logic [1:0]  port;
		logic [7:0]  wd;
		int unsigned r;
		half = 1'($urandom_range(1));
		wr = 1'($urandom_range(1));
		wd = 8'($urandom_range(255));
		r = $urandom_range(99);
		port = r < 55 ? rdpc_pkg::PORT_DATA : r < 70 ? rdpc_pkg::PORT_LOW :
			r < 85 ? rdpc_pkg::PORT_HIGH : rdpc_pkg::PORT_STATUS;
		if ((port == rdpc_pkg::PORT_LOW || port == rdpc_pkg::PORT_HIGH) && wr) begin
			// Rewriting the current value rewinds the counter for a readback.
			r = $urandom_range(9);
			if (r < 5)
				wd = sector_mirror[{half, port == rdpc_pkg::PORT_LOW}];
			else if (r < 8)
				wd = r == 5 ? 8'h00 : r == 6 ? 8'hFF : 8'h1F;
		end
		// Never read a store byte that has not been written.
		if (port == rdpc_pkg::PORT_DATA && !wr && !disk_mirror.exists(data_addr(half)))
			wr = OP_WRITE;
		issue_access(wr, {half, port}, wd, 1'b0, 8'h00);
	endtask

	always @(negedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (rdata_expected.size() == 0) begin
				$error("rdata: expected nothing, actual %02h", rdata);
				fail_count++;
			end else begin
				rdata_want = rdata_expected.pop_front();
				results_checked++;
				if (rdata !== rdata_want) begin
					$error("rdata: expected %02h, actual %02h", rdata_want, rdata);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int unsigned phase_idle [3];
		phase_idle = '{0, 46, 37};
		for (int i = 0; i < 4; i++)
			sector_mirror[i] = 8'h00;
		cnt_mirror[0] = '0;
		cnt_mirror[1] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 24; i++)
			issue_access(DIRECTED_ROWS[i].wr, DIRECTED_ROWS[i].pa, DIRECTED_ROWS[i].wd,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rd);

		// The upper half from its last sector runs past the end of the store into
		// its bottom; the lower half from its last sector runs on into the upper.
		sweep_half(HALF_HI, 8'hFF, 8'hFF, 'h210, 16);
		sweep_half(HALF_LO, 8'h3F, 8'hFF, 'h210, 16);

		for (int p = 0; p < 3; p++) begin
			idle_pct = phase_idle[p];
			for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++)
				random_access();
		end
		idle_pct = 0;
		start <= 1'b0;

		while (rdata_expected.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("%0d accesses issued, %0d results checked, %0d of them store reads;",
			beats_sent, results_checked, store_reads);
		$display("covered both halves, all ports, wrap past the end of the store and into the upper half.");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
